// ===== hw/rtl/tiis_pkg.sv =====
package tiis_pkg;

    // Field widths of the request and result items
    localparam int TIME_W   = 33;
    localparam int OFFS_W   = 32;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;

    localparam int DEFAULT_MAX_ENTRIES = 1024;

    // Request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BEFORE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_AFTER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  entry_index;
        logic [TIME_W-1:0] entry_time;
        logic [OFFS_W-1:0] entry_offset;
        logic [TIME_W-1:0] target_time;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]    found_index;
        logic [TIME_W-1:0]   found_time;
        logic [OFFS_W-1:0]   found_offset;
        logic [STATUS_W-1:0] status;
    } result_t;

    // One stored index entry: record time and byte offset side by side
    typedef struct packed {
        logic [TIME_W-1:0] rec_time;
        logic [OFFS_W-1:0] rec_offset;
    } entry_t;

endpackage

// ===== hw/rtl/tiis_mem.sv =====
module tiis_mem #(
    parameter int DEPTH = tiis_pkg::DEFAULT_MAX_ENTRIES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  tiis_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output tiis_pkg::entry_t rd_data
);
    import tiis_pkg::*;

    entry_t store_reg [DEPTH];
    entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/tiis_probe.sv =====
module tiis_probe #(
    parameter int CW = $clog2(tiis_pkg::DEFAULT_MAX_ENTRIES + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tiis_pkg::TIME_W-1:0] gap,
    input  logic [tiis_pkg::TIME_W-1:0] span,
    input  logic [CW-1:0]               width,
    output logic                        done,
    output logic [CW-1:0]               quot
);
    import tiis_pkg::*;

    localparam int PW = TIME_W + CW;
    localparam int SW = $clog2(CW + 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_INIT = 2'd2;
    localparam logic [1:0] P_DIV  = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [SW-1:0]     cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [TIME_W-1:0] a_reg, a_next;
    logic [CW-1:0]     b_reg, b_next;
    logic [TIME_W-1:0] d_reg, d_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]     lo_reg, lo_next;

    logic [TIME_W:0]   shifted;
    logic [TIME_W:0]   diff;
    logic              ge;

    // One restoring division step: the quotient fits in CW bits, so the
    // upper product bits already sit below the divisor
    always_comb
    begin
        shifted = {rem_reg, lo_reg[CW-1]};
        diff    = shifted - {1'b0, d_reg};
        ge      = shifted >= {1'b0, d_reg};
    end

    // Sequence: latch operands, multiply, load remainder, CW division steps
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    a_next     = gap;
                    b_next     = width;
                    d_next     = span;
                    phase_next = P_MUL;
                end
            end
            P_MUL:
            begin
                prod_next  = {{CW{1'b0}}, a_reg} * {{TIME_W{1'b0}}, b_reg};
                phase_next = P_INIT;
            end
            P_INIT:
            begin
                rem_next   = prod_reg[PW-1:CW];
                lo_next    = prod_reg[CW-1:0];
                cnt_next   = SW'(CW - 1);
                phase_next = P_DIV;
            end
            P_DIV:
            begin
                rem_next = ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
                lo_next  = {lo_reg[CW-2:0], ge};
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    phase_next = P_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule

// ===== hw/rtl/time_index_interpolation_seek.sv =====
// Time index seek: holds up to MAX_ENTRIES record times (ascending) and byte
// offsets in one single-port-read memory, filled by load requests; a query
// request runs an interpolation search over the first entry_count entries
// and returns the chosen index, time, offset and a status (found, before
// start, after end, loaded; after end reports the first entry's time). One
// request is worked at a time and its result sits in an output register, so
// the next request is taken while that result waits. A load goes straight to
// the output hand-off. A query reads the first and last entries, then each
// probe runs the multiplier and the one-bit-per-cycle divider (quotient width
// CW = clog2(MAX_ENTRIES + 1)); a probe over a zero time span skips both, and
// a last step hands the result to the output register. The probe count
// depends on the data and is bounded by MAX_ENTRIES + 2. Memory contents are
// undefined after reset: query only loaded entries. entry_count resets to 1;
// the user must write it only while the block is idle, as the block does not
// enforce this.
module time_index_interpolation_seek #(
    parameter int MAX_ENTRIES = tiis_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  tiis_pkg::item_t            item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output tiis_pkg::result_t          result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tiis_pkg::CNT_W-1:0] cfg_data
);
    import tiis_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES + 2);
    localparam logic [IW-1:0] ITER_LAST = IW'(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RD_FIRST = 3'd1;
    localparam logic [2:0] S_RD_LAST  = 3'd2;
    localparam logic [2:0] S_PROBE    = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_CHECK    = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] tval_reg, tval_next;
    logic [CW-1:0]     nm1_reg, nm1_next;
    logic [TIME_W-1:0] first_time_reg, first_time_next;
    logic [OFFS_W-1:0] first_off_reg, first_off_next;
    logic [TIME_W-1:0] stime_reg, stime_next;
    logic [TIME_W-1:0] etime_reg, etime_next;
    logic [CW-1:0]     srec_reg, srec_next;
    logic [CW-1:0]     erec_reg, erec_next;
    logic [CW-1:0]     rec_reg, rec_next;
    logic [CW-1:0]     prec_reg, prec_next;
    logic [IW-1:0]     iter_reg, iter_next;
    result_t           pend_reg, pend_next;
    result_t           result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic              accept;
    logic [31:0]       cnt_wide;
    logic [31:0]       n_wide;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    entry_t            mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    entry_t            mem_rd_data;
    logic              probe_start;
    logic              probe_done;
    logic [CW-1:0]     probe_quot;
    logic [CW-1:0]     cand_raw;
    logic [CW-1:0]     cand;
    logic              out_free;
    logic              stop;

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);
    assign out_free   = !result_valid_reg || !result_stall;

    // Clamp the searched entry count to 1..MAX_ENTRIES
    always_comb
    begin
        cnt_wide = 32'(count_reg);
        if (cnt_wide == 32'd0)
        begin
            n_wide = 32'd1;
        end
        else if (cnt_wide > 32'(MAX_ENTRIES))
        begin
            n_wide = 32'(MAX_ENTRIES);
        end
        else
        begin
            n_wide = cnt_wide;
        end
    end

    // Probe index: lower bound (+ quotient if divided), held to last entry
    always_comb
    begin
        cand_raw = (state_reg == S_PROBE) ? srec_reg : (srec_reg + probe_quot);
        cand     = (cand_raw > nm1_reg) ? nm1_reg : cand_raw;
    end

    // Load write port
    always_comb
    begin
        mem_wr_en            = accept && (item.kind == KIND_LOAD)
                               && (32'(item.entry_index) < 32'(MAX_ENTRIES));
        mem_wr_addr          = AW'(item.entry_index);
        mem_wr_data.rec_time   = item.entry_time;
        mem_wr_data.rec_offset = item.entry_offset;
    end

    assign stop = ((iter_reg != '0) && (prec_reg == rec_reg)) || (iter_reg == ITER_LAST);

    // Search sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        tval_next       = tval_reg;
        nm1_next        = nm1_reg;
        first_time_next = first_time_reg;
        first_off_next  = first_off_reg;
        stime_next      = stime_reg;
        etime_next      = etime_reg;
        srec_next       = srec_reg;
        erec_next       = erec_reg;
        rec_next        = rec_reg;
        prec_next       = prec_reg;
        iter_next       = iter_reg;
        pend_next       = pend_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        probe_start     = 1'b0;

        if (cfg_valid)
        begin
            count_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tval_next = item.target_time;
                    nm1_next  = CW'(n_wide - 32'd1);
                    if (item.kind == KIND_LOAD)
                    begin
                        pend_next.found_index  = '0;
                        pend_next.found_time   = '0;
                        pend_next.found_offset = '0;
                        pend_next.status       = ST_LOADED;
                        state_next             = S_EMIT;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        state_next  = S_RD_FIRST;
                    end
                end
            end
            S_RD_FIRST:
            begin
                first_time_next = mem_rd_data.rec_time;
                first_off_next  = mem_rd_data.rec_offset;
                mem_rd_en       = 1'b1;
                mem_rd_addr     = AW'(nm1_reg);
                state_next      = S_RD_LAST;
            end
            S_RD_LAST:
            begin
                if (tval_reg < first_time_reg)
                begin
                    pend_next.found_index  = '0;
                    pend_next.found_time   = first_time_reg;
                    pend_next.found_offset = first_off_reg;
                    pend_next.status       = ST_BEFORE;
                    state_next             = S_EMIT;
                end
                else if (tval_reg > mem_rd_data.rec_time)
                begin
                    pend_next.found_index  = IDX_W'(nm1_reg);
                    pend_next.found_time   = first_time_reg;
                    pend_next.found_offset = mem_rd_data.rec_offset;
                    pend_next.status       = ST_AFTER;
                    state_next             = S_EMIT;
                end
                else
                begin
                    stime_next = first_time_reg;
                    etime_next = mem_rd_data.rec_time;
                    srec_next  = '0;
                    erec_next  = nm1_reg + 1'b1;
                    rec_next   = '0;
                    prec_next  = '0;
                    iter_next  = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (etime_reg <= stime_reg)
                begin
                    // Zero span: take the lower bound
                    prec_next   = rec_reg;
                    rec_next    = cand;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(cand);
                    state_next  = S_CHECK;
                end
                else
                begin
                    probe_start = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (probe_done)
                begin
                    prec_next   = rec_reg;
                    rec_next    = cand;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(cand);
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                pend_next.found_index  = IDX_W'(rec_reg);
                pend_next.found_time   = mem_rd_data.rec_time;
                pend_next.found_offset = mem_rd_data.rec_offset;
                pend_next.status       = ST_FOUND;
                if (mem_rd_data.rec_time == tval_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    // Narrow the bracket around the target
                    if (mem_rd_data.rec_time < tval_reg)
                    begin
                        srec_next  = rec_reg;
                        stime_next = mem_rd_data.rec_time;
                    end
                    else
                    begin
                        erec_next  = rec_reg;
                        etime_next = mem_rd_data.rec_time;
                    end
                    if (stop)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        iter_next  = iter_reg + 1'b1;
                        state_next = S_PROBE;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: hold until taken, load the pending result when free
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if ((state_reg == S_EMIT) && out_free)
        begin
            result_valid_next = 1'b1;
            result_next       = pend_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= CNT_W'(1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        tval_reg       <= tval_next;
        nm1_reg        <= nm1_next;
        first_time_reg <= first_time_next;
        first_off_reg  <= first_off_next;
        stime_reg      <= stime_next;
        etime_reg      <= etime_next;
        srec_reg       <= srec_next;
        erec_reg       <= erec_next;
        rec_reg        <= rec_next;
        prec_reg       <= prec_next;
        iter_reg       <= iter_next;
        pend_reg       <= pend_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    tiis_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tiis_probe #(
        .CW (CW)
    ) u_probe (
        .clk   (clk),
        .rst_n (rst_n),
        .start (probe_start),
        .gap   (tval_reg - stime_reg),
        .span  (etime_reg - stime_reg),
        .width (erec_reg - srec_reg),
        .done  (probe_done),
        .quot  (probe_quot)
    );

endmodule

// ===== tb/time_index_interpolation_seek_tb.sv =====
`timescale 1ns / 100ps

module time_index_interpolation_seek_tb;
    import tiis_pkg::*;

    localparam int MAX_ENTRIES = DEFAULT_MAX_ENTRIES;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 1;
    localparam longint unsigned OFFS_MAX = (64'd1 << OFFS_W) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 64;

    // How a phase fills the searched part of the table
    typedef enum int {
        SPREAD,
        DENSE,
        SHUFFLED
    } table_style_e;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    item_t             item = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data = '0;

    // Requests waiting to be offered, and the results they must produce
    item_t             request_queue[$];
    result_t           awaited_results[$];
    result_t           want;

    // Shadow of the index tables and of the entry count
    logic [TIME_W-1:0] rec_time_copy[MAX_ENTRIES];
    logic [OFFS_W-1:0] rec_offset_copy[MAX_ENTRIES];
    logic [CNT_W-1:0]  searched_count = CNT_W'(1);

    // Times as planned by the stimulus, used to aim queries
    longint unsigned   planned_time[MAX_ENTRIES];

    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    bit                hold_armed = 1'b0;
    bit                hold_done = 1'b0;
    int                hold_left = 0;
    int                mismatches = 0;

    time_index_interpolation_seek dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Apply one request to the shadow tables and work out its result
    function automatic result_t seek_result(item_t req);
        result_t res;
        longint unsigned n, tval, first, last, stime, etime, srec, erec, rec, prec, t;
        int iter;
        res = '0;
        if (req.kind == KIND_LOAD)
        begin
            if (req.entry_index < MAX_ENTRIES)
            begin
                rec_time_copy[AW'(req.entry_index)] = req.entry_time;
                rec_offset_copy[AW'(req.entry_index)] = req.entry_offset;
            end
            res.status = ST_LOADED;
            return res;
        end
        // clamp the count into 1..MAX_ENTRIES
        n = 64'(searched_count);
        if (n == 0)
            n = 1;
        if (n > MAX_ENTRIES)
            n = MAX_ENTRIES;
        tval = 64'(req.target_time);
        first = 64'(rec_time_copy[0]);
        last = 64'(rec_time_copy[AW'(n - 1)]);
        if (tval < first)
        begin
            res.found_time = TIME_W'(first);
            res.found_offset = rec_offset_copy[0];
            res.status = ST_BEFORE;
            return res;
        end
        // past the end still reports the first entry's time
        if (tval > last)
        begin
            res.found_index = IDX_W'(n - 1);
            res.found_time = TIME_W'(first);
            res.found_offset = rec_offset_copy[AW'(n - 1)];
            res.status = ST_AFTER;
            return res;
        end
        stime = first;
        etime = last;
        srec = 0;
        erec = n;
        rec = 0;
        for (iter = 0; iter < MAX_ENTRIES + 2; iter++)
        begin
            prec = rec;
            // equal bounds pick the lower bound, else interpolate with floor division
            if (etime <= stime)
                rec = srec;
            else
                rec = srec + (tval - stime) * (erec - srec) / (etime - stime);
            if (rec > n - 1)
                rec = n - 1;
            t = 64'(rec_time_copy[AW'(rec)]);
            if (t == tval)
                break;
            if (t < tval)
            begin
                srec = rec;
                stime = t;
            end
            else
            begin
                erec = rec;
                etime = t;
            end
            if (iter > 0 && prec == rec)
                break;
        end
        res.found_index = IDX_W'(rec);
        res.found_time = rec_time_copy[AW'(rec)];
        res.found_offset = rec_offset_copy[AW'(rec)];
        res.status = ST_FOUND;
        return res;
    endfunction

    // Uniform value in 0..maxv over the full 64-bit range
    function automatic longint unsigned rand_upto(longint unsigned maxv);
        longint unsigned v;
        v = {$urandom, $urandom};
        return v % (maxv + 1);
    endfunction

    function automatic void push_load(int idx, longint unsigned t, longint unsigned off);
        item_t req;
        req.kind = KIND_LOAD;
        req.entry_index = IDX_W'(idx);
        req.entry_time = TIME_W'(t);
        req.entry_offset = OFFS_W'(off);
        req.target_time = TIME_W'(rand_upto(TIME_MAX));
        planned_time[AW'(idx)] = t;
        request_queue.push_back(req);
    endfunction

    function automatic void push_query(longint unsigned t);
        item_t req;
        req.kind = KIND_QUERY;
        req.entry_index = IDX_W'($urandom_range(MAX_ENTRIES - 1));
        req.entry_time = TIME_W'(rand_upto(TIME_MAX));
        req.entry_offset = OFFS_W'($urandom);
        req.target_time = TIME_W'(t);
        request_queue.push_back(req);
    endfunction

    // Aim mostly at stored times and the gaps between them, sometimes outside
    function automatic longint unsigned pick_target(int n);
        longint unsigned first, last;
        int roll;
        first = planned_time[0];
        last = planned_time[AW'(n - 1)];
        roll = $urandom_range(99);
        if (roll < 55)
            return planned_time[AW'($urandom_range(n - 1))];
        if (roll < 75 && last >= first)
            return first + rand_upto(last - first);
        if (roll < 85)
            return (first == 0) ? 0 : rand_upto(first - 1);
        if (roll < 95)
            return (last >= TIME_MAX) ? TIME_MAX : last + 1 + rand_upto(TIME_MAX - last - 1);
        return rand_upto(TIME_MAX);
    endfunction

    // Wait until no request is pending and every result has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (request_queue.size() != 0 || item_valid || awaited_results.size() != 0);
    endtask

    task automatic write_entry_count(input logic [CNT_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        searched_count = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Set the count, load a fresh table if asked, then mix queries with reloads
    task automatic run_search_phase(input int count_value, input int queries,
                                    input table_style_e style, input bit reload);
        longint unsigned t, step_max;
        int n, i, idx;
        n = (count_value == 0) ? 1 : ((count_value > MAX_ENTRIES) ? MAX_ENTRIES : count_value);
        write_entry_count(CNT_W'(count_value));
        if (reload)
        begin
            step_max = (style == DENSE) ? 3 : TIME_MAX / n;
            t = (style == DENSE) ? rand_upto(TIME_MAX - 3 * n) : rand_upto(step_max);
            for (i = 0; i < n; i++)
            begin
                if (style == SHUFFLED)
                    t = rand_upto(TIME_MAX);
                else if (i != 0)
                    t += rand_upto(step_max);
                push_load(i, t, $urandom);
                // stray load beyond the searched range
                if (n < MAX_ENTRIES && $urandom_range(9) == 0)
                    push_load($urandom_range(MAX_ENTRIES - 1, n), rand_upto(TIME_MAX),
                              $urandom);
            end
        end
        for (i = 0; i < queries; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                idx = $urandom_range(n - 1);
                push_load(idx, planned_time[AW'(idx)], $urandom);
            end
            else
                push_query(pick_target(n));
        end
    endtask

    // Driver: predict each request as it is taken, then offer the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                awaited_results.push_back(seek_result(item));
            if (!item_valid || !item_stall)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item <= request_queue.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each taken result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result arrived with no request awaiting it");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.found_index !== want.found_index)
                    begin
                        $error("found_index: expected %0d, actual %0d",
                               want.found_index, result.found_index);
                        mismatches++;
                    end
                    if (result.found_time !== want.found_time)
                    begin
                        $error("found_time: expected %0d, actual %0d",
                               want.found_time, result.found_time);
                        mismatches++;
                    end
                    if (result.found_offset !== want.found_offset)
                    begin
                        $error("found_offset: expected %0d, actual %0d",
                               want.found_offset, result.found_offset);
                        mismatches++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        mismatches++;
                    end
                end
            end
            // hold off once for a long stretch so the block backs up
            if (hold_left != 0)
                hold_left--;
            else if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        int p, n;
        table_style_e style;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct = 14;
        recv_idle_pct = 69;

        // single entry under the reset count: below, on and above it
        push_load(0, 1000, OFFS_MAX);
        push_query(999);
        push_query(1000);
        push_query(1001);
        push_load(MAX_ENTRIES - 1, TIME_MAX, 0);

        // a zero count searches one entry
        write_entry_count(0);
        push_query(0);
        push_query(TIME_MAX);

        // four entries with a repeated first time
        write_entry_count(4);
        push_load(1, 1000, 32'h0000_0001);
        push_load(2, 5000, 32'h8000_0000);
        push_load(3, 9000, 32'h5555_aaaa);
        push_query(5000);
        push_query(3000);
        push_query(9000);
        push_query(9001);
        push_query(1000);

        // both bounds equal
        write_entry_count(2);
        push_query(1000);

        // time zero at the head of the table
        write_entry_count(4);
        push_load(0, 0, 32'h1234_5678);
        push_query(0);
        push_query(2000);

        // light sender gaps, heavy receiver stalls
        for (p = 0; p < 5; p++)
        begin
            n = (p == 0) ? 32 : ((p == 1) ? 1 : $urandom_range(48, 2));
            style = (p == 3) ? SHUFFLED : (($urandom_range(1) != 0) ? SPREAD : DENSE);
            run_search_phase(n, 16, style, 1'b1);
            if (p == 0)
                hold_armed = 1'b1;
        end

        // heavy sender gaps, light receiver stalls, whole table
        send_idle_pct = 69;
        recv_idle_pct = 14;
        run_search_phase(MAX_ENTRIES, 40, SPREAD, 1'b1);
        run_search_phase((1 << CNT_W) - 1, 20, SPREAD, 1'b0);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (p = 0; p < 5; p++)
        begin
            n = $urandom_range(48, 2);
            style = (p == 2) ? SHUFFLED : (($urandom_range(1) != 0) ? SPREAD : DENSE);
            run_search_phase(n, 16, style, 1'b1);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("time_index_interpolation_seek_tb passed");
        else
            $display("time_index_interpolation_seek_tb failed");
        $finish;
    end

    // Give up long after the slowest correct run
    initial
    begin
        #(64'd250_000_000);
        $display("time_index_interpolation_seek_tb failed");
        $finish;
    end

endmodule

// ===== time_index_interpolation_seek.f =====
hw/rtl/tiis_pkg.sv
hw/rtl/tiis_mem.sv
hw/rtl/tiis_probe.sv
hw/rtl/time_index_interpolation_seek.sv
tb/time_index_interpolation_seek_tb.sv
